// ===== hw/rtl/vhf_pkg.sv =====
// Shared constants for the vertical horizontal filter unit.
// No dependencies; used by vhf_front, vhf_back and the top level.
package vhf_pkg;

    localparam int DEF_MAX_PERIOD  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int PERIOD_BITS = 7;
    localparam int RATIO_BITS  = 17;
    localparam int QUOT_STEPS  = 17;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 7'd28;
    localparam logic [RATIO_BITS-1:0]  RATIO_ONE    = 17'd65536;

endpackage

// ===== hw/rtl/vhf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vhf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/vhf_front.sv =====
// Front end: accepts samples, turns them into offset binary and queues them.
// Depends on vhf_pkg.
module vhf_front
    import vhf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic                          q_valid,
    output logic [SAMPLE_BITS-1:0]        q_data,
    input  logic                          q_pop,
    output logic                          q_empty
);

    logic [SAMPLE_BITS-1:0] entry_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic                   push;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_empty  = (count_reg == 2'd0);
    assign q_data   = entry_reg[rd_ptr_reg];

    // Flipping the sign bit makes unsigned compares and differences valid.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/vhf_back.sv =====
// Back end: stores samples in the history RAM, scans the window, divides
// and holds the result register. Depends on vhf_pkg and vhf_ram.
module vhf_back
    import vhf_pkg::*;
#(
    parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [SAMPLE_BITS-1:0] q_data,
    output logic                   q_pop,
    input  logic                   cfg_write,
    input  logic [PERIOD_BITS-1:0] cfg_data,
    output logic                   idle,
    output logic [RATIO_BITS-1:0]  ratio,
    output logic                   out_valid,
    input  logic                   out_stall
);

    localparam int DEPTH = MAX_PERIOD + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_PERIOD + 2);
    localparam int CMPW  = (CW > PERIOD_BITS) ? CW : PERIOD_BITS;
    localparam int SUMW  = SAMPLE_BITS + $clog2(MAX_PERIOD + 1);
    localparam int REMW  = SUMW + 1;
    localparam int DCW   = $clog2(QUOT_STEPS);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DIV,
        B_OUT
    } state_t;

    state_t                 state_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [AW-1:0]          wp_reg;
    logic [CW-1:0]          fill_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [CW-1:0]          iss_k_reg;
    logic                   iss_on_reg;
    logic                   proc_v_reg;
    logic [CW-1:0]          proc_k_reg;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SUMW-1:0]        sum_reg;
    logic [REMW-1:0]        rem_reg;
    logic [RATIO_BITS-1:0]  q_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   out_valid_reg;
    logic [RATIO_BITS-1:0]  ratio_reg;

    logic [CMPW-1:0]        p_wide;
    logic [CW-1:0]          p_eff;
    logic [CW-1:0]          fill_next;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] diff;
    logic [REMW-1:0]        rem_try;
    logic                   rem_ge;
    logic                   out_free;

    always_comb
    begin
        p_wide = CMPW'(period_reg);
        if (p_wide < CMPW'(2))
        begin
            p_wide = CMPW'(2);
        end
        else if (p_wide > CMPW'(MAX_PERIOD))
        begin
            p_wide = CMPW'(MAX_PERIOD);
        end
        p_eff = CW'(p_wide);
    end

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign fill_next = (fill_reg < p_eff + CW'(1)) ? fill_reg + CW'(1) : fill_reg;
    assign diff      = (prev_reg > rdata) ? prev_reg - rdata : rdata - prev_reg;
    assign rem_try   = (dcnt_reg == '0) ? rem_reg : (rem_reg << 1);
    assign rem_ge    = (sum_reg != '0) && (rem_try >= REMW'(sum_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign idle      = (state_reg == B_IDLE) && !out_valid_reg;
    assign ratio     = ratio_reg;
    assign out_valid = out_valid_reg;

    vhf_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (q_pop),
        .waddr(wp_reg),
        .wdata(q_data),
        .re   (iss_on_reg),
        .raddr(rd_addr_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            period_reg    <= PERIOD_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_addr_reg   <= '0;
            iss_k_reg     <= '0;
            iss_on_reg    <= 1'b0;
            proc_v_reg    <= 1'b0;
            proc_k_reg    <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            ratio_reg     <= '0;
        end
        else
        begin
            proc_v_reg <= iss_on_reg;
            proc_k_reg <= iss_k_reg;
            // A new result loaded in the output state takes the place of the old one.
            if (out_valid_reg && !out_stall && (state_reg != B_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                period_reg <= cfg_data;
                fill_reg   <= '0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        wp_reg   <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                        fill_reg <= fill_next;
                        if (fill_next == p_eff + CW'(1))
                        begin
                            // The newest sample sits at the old write pointer.
                            rd_addr_reg <= wp_reg;
                            iss_k_reg   <= '0;
                            iss_on_reg  <= 1'b1;
                            state_reg   <= B_SCAN;
                        end
                    end
                end
                B_SCAN:
                begin
                    if (iss_on_reg)
                    begin
                        rd_addr_reg <= (rd_addr_reg == '0) ? AW'(DEPTH - 1)
                                                           : rd_addr_reg - AW'(1);
                        iss_k_reg   <= iss_k_reg + CW'(1);
                        if (iss_k_reg == p_eff)
                        begin
                            iss_on_reg <= 1'b0;
                        end
                    end
                    if (proc_v_reg)
                    begin
                        prev_reg <= rdata;
                        if (proc_k_reg == '0)
                        begin
                            hi_reg  <= rdata;
                            lo_reg  <= rdata;
                            sum_reg <= '0;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + SUMW'(diff);
                            if (proc_k_reg != p_eff)
                            begin
                                if (rdata > hi_reg)
                                begin
                                    hi_reg <= rdata;
                                end
                                if (rdata < lo_reg)
                                begin
                                    lo_reg <= rdata;
                                end
                            end
                            else
                            begin
                                // The oldest sample adds a change but not an extreme.
                                rem_reg   <= REMW'(hi_reg - lo_reg);
                                q_reg     <= '0;
                                dcnt_reg  <= '0;
                                state_reg <= B_DIV;
                            end
                        end
                    end
                end
                B_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_try - REMW'(sum_reg) : rem_try;
                    q_reg    <= {q_reg[RATIO_BITS-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(QUOT_STEPS - 1))
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        ratio_reg     <= (q_reg > RATIO_ONE) ? RATIO_ONE : q_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/vertical_horizontal_filter_unit.sv =====
// Top level of the vertical horizontal filter unit.
// Depends on vhf_pkg, vhf_front and vhf_back.
//
// Input channel: sample with in_valid/in_stall; a request is taken when
// in_valid is high and in_stall is low. A two-entry queue sits in front,
// so in_stall rises only when two samples wait behind the one in work.
// Output channel: ratio (unsigned Q1.16) with out_valid/out_stall. The
// result register holds its value while out_stall is high; the back end
// then waits with a finished quotient and the queue keeps filling.
// Configuration: period with cfg_valid/cfg_ready; cfg_ready is high only
// when the queue is empty, the back end is idle and no result waits.
// A write clears the fill count, so effective period+1 new samples are needed again.
// Work per sample with effective period P: the sample is stored, then,
// once the window is full, the last P+1 samples are scanned from the history
// RAM through its single read port, the radix-2 divider forms the quotient
// and the result is loaded. While the window fills, a sample is only stored.
// Reset clears the fill count, queue and result register and sets the
// period to 28.
module vertical_horizontal_filter_unit
    import vhf_pkg::*;
#(
    parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic [RATIO_BITS-1:0]         ratio,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  logic [PERIOD_BITS-1:0]        period,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

    logic                   q_valid;
    logic [SAMPLE_BITS-1:0] q_data;
    logic                   q_pop;
    logic                   q_empty;
    logic                   back_idle;

    assign cfg_ready = q_empty && back_idle;

    vhf_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .q_empty (q_empty)
    );

    vhf_back #(
        .MAX_PERIOD (MAX_PERIOD),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_data (period),
        .idle     (back_idle),
        .ratio    (ratio),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

`ifndef SYNTHESIS
    // The ratio never exceeds one.
    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ratio <= RATIO_ONE))
        else $error("ratio above one");

    // Configuration is offered only with no result pending.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid)
        else $error("cfg_ready while a result waits");

    // A period write clears the fill count, so no result follows at once.
    a_cfg_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !out_valid)
        else $error("result right after a period write");
`endif

endmodule
